>>> rtl/svpt_pkg.sv
// Shared types and constants for the space-vector PWM sector timing block.
// Used by every module in rtl/; depends on nothing.
`default_nettype none

package svpt_pkg;

   // Classified-request queue between front and back
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

   // Register reset value and Q15 full scale
   localparam logic [14:0] PERIOD_RESET = 15'd2400;
   localparam logic [15:0] Q15_MAX      = 16'd32767;

   // One quotient bit per divider stage
   localparam int unsigned DIV_STEPS = 15;

   // Result fifo depth at the back end
   localparam logic [1:0] OUT_DEPTH = 2'd2;

   typedef enum logic [2:0] {
      SECTOR_1 = 3'd1,
      SECTOR_2 = 3'd2,
      SECTOR_3 = 3'd3,
      SECTOR_4 = 3'd4,
      SECTOR_5 = 3'd5,
      SECTOR_6 = 3'd6
   } sector_type;

   // Request after classification: sector, scale flag, the two magnitudes and their sum
   typedef struct packed {
      sector_type  sector;
      logic        scale;
      logic [14:0] t1;
      logic [14:0] t2;
      logic [15:0] sum;
   } cls_type;

   // One finished result
   typedef struct packed {
      logic [14:0] duty_ch0;
      logic [14:0] duty_ch1;
      logic [14:0] duty_ch2;
      sector_type  sector;
   } rsp_type;

endpackage

`default_nettype wire

>>> rtl/svpt_front.sv
// Front end: accepts reference requests and classifies them into a sector.
// Depends on svpt_pkg; feeds svpt_queue.
`default_nettype none

module svpt_front (
   input  logic                  req_push,
   output logic                  req_full,
   input  logic signed [15:0]    ref_a,
   input  logic signed [15:0]    ref_b,
   input  logic signed [15:0]    ref_c,
   input  logic                  q_full,
   output logic                  q_push,
   output svpt_pkg::cls_type     q_item
);
   import svpt_pkg::*;

   // Magnitude of a negative Q15 value, saturating -32768 to 32767
   function automatic logic [14:0] mag_neg(input logic signed [15:0] v);
      logic [15:0] n;
      n = 16'd0 - v;
      if (v == 16'sh8000) begin
         return 15'h7fff;
      end
      return n[14:0];
   endfunction

   logic        sa, sb, sc;
   sector_type  sector_w;
   logic [14:0] t1_w;
   logic [14:0] t2_w;
   logic [15:0] sum_w;

   assign sa = ref_a[15];
   assign sb = ref_b[15];
   assign sc = ref_c[15];

   // Sector from the signs, with the two magnitudes that go with it
   always_comb begin
      sector_w = SECTOR_4;
      t1_w     = mag_neg(ref_b);
      t2_w     = mag_neg(ref_a);
      if (!sa) begin
         if (!sb) begin
            sector_w = SECTOR_3;
            t1_w     = ref_a[14:0];
            t2_w     = ref_b[14:0];
         end else if (!sc) begin
            sector_w = SECTOR_5;
            t1_w     = ref_c[14:0];
            t2_w     = ref_a[14:0];
         end else begin
            sector_w = SECTOR_1;
            t1_w     = mag_neg(ref_c);
            t2_w     = mag_neg(ref_b);
         end
      end else if (!sb) begin
         if (!sc) begin
            sector_w = SECTOR_6;
            t1_w     = ref_b[14:0];
            t2_w     = ref_c[14:0];
         end else begin
            sector_w = SECTOR_2;
            t1_w     = mag_neg(ref_a);
            t2_w     = mag_neg(ref_c);
         end
      end
   end

   // Pair needs scaling when the sum reaches full scale
   assign sum_w = {1'b0, t1_w} + {1'b0, t2_w};

   always_comb begin
      q_item.sector = sector_w;
      q_item.scale  = (sum_w >= Q15_MAX);
      q_item.t1     = t1_w;
      q_item.t2     = t2_w;
      q_item.sum    = sum_w;
   end

   assign req_full = q_full;
   assign q_push   = req_push && !q_full;

endmodule

`default_nettype wire

>>> rtl/svpt_queue.sv
// Short queue of classified requests between the front and back ends.
// Depends on svpt_pkg.
`default_nettype none

module svpt_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  svpt_pkg::cls_type  item_in,
   output logic               full,
   input  logic               pop,
   output svpt_pkg::cls_type  item_out,
   output logic               empty
);
   import svpt_pkg::*;

   cls_type             entry_ff [0:QUEUE_DEPTH-1];
   logic [QUEUE_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_AW:0]   cnt_ff, cnt_in;
   logic                do_push, do_pop;

   assign full     = (cnt_ff == (QUEUE_AW+1)'(QUEUE_DEPTH));
   assign empty    = (cnt_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign item_out = entry_ff[rd_ptr_ff];

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= item_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/svpt_back.sv
// Back end: pipelined scaling divider, period multiply, time forming and
// per-sector channel mapping, ending in a two-entry result fifo. Uses svpt_pkg.
`default_nettype none

module svpt_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [14:0]            period,
   input  logic                   q_empty,
   input  svpt_pkg::cls_type      q_item,
   output logic                   q_pop,
   output logic                   rsp_empty,
   input  logic                   rsp_pop,
   output logic [14:0]            rsp_duty_ch0,
   output logic [14:0]            rsp_duty_ch1,
   output logic [14:0]            rsp_duty_ch2,
   output logic [2:0]             rsp_sector_num
);
   import svpt_pkg::*;

   // One divider lane: partial remainder and numerator/quotient shift word
   typedef struct packed {
      logic [15:0] rem;
      logic [14:0] low;
   } div_lane_type;

   typedef struct packed {
      sector_type   sector;
      logic         scale;
      logic [15:0]  sum;
      div_lane_type l1;
      div_lane_type l2;
   } div_stage_type;

   typedef struct packed {
      sector_type  sector;
      logic [14:0] p1;
      logic [14:0] p2;
   } mul_stage_type;

   typedef struct packed {
      sector_type  sector;
      logic [14:0] lo;
      logic [14:0] h1;
      logic [14:0] h2;
   } tim_stage_type;

   // Load a lane: numerator t*32767 when scaling, else t passes through rem
   function automatic div_lane_type div_prep(input logic [14:0] t, input logic scale);
      logic [29:0]  num;
      div_lane_type y;
      num = {t, 15'd0} - {15'd0, t};
      if (scale) begin
         y.rem = {1'b0, num[29:15]};
         y.low = num[14:0];
      end else begin
         y.rem = 16'd0;
         y.low = t;
      end
      return y;
   endfunction

   // One restoring step; without scaling no subtract, so t shifts into rem
   function automatic div_lane_type div_step(input div_lane_type x, input logic [15:0] d,
                                             input logic en);
      logic [16:0]  tmp;
      logic [16:0]  dif;
      div_lane_type y;
      tmp = {x.rem, x.low[14]};
      dif = tmp - {1'b0, d};
      if (en && (tmp >= {1'b0, d})) begin
         y.rem = dif[15:0];
         y.low = {x.low[13:0], 1'b1};
      end else begin
         y.rem = tmp[15:0];
         y.low = {x.low[13:0], 1'b0};
      end
      return y;
   endfunction

   function automatic logic [14:0] div_result(input div_lane_type x, input logic scale);
      return scale ? x.low : x.rem[14:0];
   endfunction

   function automatic logic [14:0] at_least_one(input logic [14:0] v);
      return (v == 15'd0) ? 15'd1 : v;
   endfunction

   logic [DIV_STEPS:0] div_vld_ff, div_vld_in;
   div_stage_type      div_ff [0:DIV_STEPS];
   div_stage_type      div_in [0:DIV_STEPS];
   logic               mul_vld_ff, mul_vld_in;
   mul_stage_type      mul_ff, mul_in;
   logic               tim_vld_ff, tim_vld_in;
   tim_stage_type      tim_ff, tim_in;
   logic               b_vld_ff, b_vld_in;
   rsp_type            b_ff, b_in;

   rsp_type            out_mem_ff [0:1];
   logic               out_wr_ff, out_wr_in;
   logic               out_rd_ff, out_rd_in;
   logic [1:0]         out_cnt_ff, out_cnt_in;

   logic               adv;
   logic               out_push, out_pop;
   logic [14:0]        q1, q2;
   logic [29:0]        prod1, prod2;
   logic [16:0]        diff;
   logic [15:0]        mid_w, hi_w;
   logic [14:0]        lo_c, mid_c, hi_c;

   // Whole pipeline moves unless the last stage is held by a full fifo
   assign adv      = !b_vld_ff || (out_cnt_ff != OUT_DEPTH);
   assign q_pop    = adv && !q_empty;
   assign out_push = adv && b_vld_ff;
   assign out_pop  = rsp_pop && !rsp_empty;

   // Divider stages
   always_comb begin
      div_vld_in = div_vld_ff;
      div_in     = div_ff;
      if (adv) begin
         div_vld_in[0]    = !q_empty;
         div_in[0].sector = q_item.sector;
         div_in[0].scale  = q_item.scale;
         div_in[0].sum    = q_item.sum;
         div_in[0].l1     = div_prep(q_item.t1, q_item.scale);
         div_in[0].l2     = div_prep(q_item.t2, q_item.scale);
         for (int i = 1; i <= DIV_STEPS; i++) begin
            div_vld_in[i]    = div_vld_ff[i-1];
            div_in[i].sector = div_ff[i-1].sector;
            div_in[i].scale  = div_ff[i-1].scale;
            div_in[i].sum    = div_ff[i-1].sum;
            div_in[i].l1     = div_step(div_ff[i-1].l1, div_ff[i-1].sum, div_ff[i-1].scale);
            div_in[i].l2     = div_step(div_ff[i-1].l2, div_ff[i-1].sum, div_ff[i-1].scale);
         end
      end
   end

   // Vector times scaled by the period, Q15 product
   assign q1    = div_result(div_ff[DIV_STEPS].l1, div_ff[DIV_STEPS].scale);
   assign q2    = div_result(div_ff[DIV_STEPS].l2, div_ff[DIV_STEPS].scale);
   assign prod1 = 30'(period) * 30'(q1);
   assign prod2 = 30'(period) * 30'(q2);

   always_comb begin
      mul_vld_in = mul_vld_ff;
      mul_in     = mul_ff;
      if (adv) begin
         mul_vld_in    = div_vld_ff[DIV_STEPS];
         mul_in.sector = div_ff[DIV_STEPS].sector;
         mul_in.p1     = prod1[29:15];
         mul_in.p2     = prod2[29:15];
      end
   end

   // Low time, clamped at zero, and the two half vectors
   assign diff = {2'b00, period} - {2'b00, mul_ff.p1} - {2'b00, mul_ff.p2};

   always_comb begin
      tim_vld_in = tim_vld_ff;
      tim_in     = tim_ff;
      if (adv) begin
         tim_vld_in    = mul_vld_ff;
         tim_in.sector = mul_ff.sector;
         tim_in.lo     = diff[16] ? 15'd0 : {2'b00, diff[14:2]};
         tim_in.h1     = {1'b0, mul_ff.p1[14:1]};
         tim_in.h2     = {1'b0, mul_ff.p2[14:1]};
      end
   end

   // Stacked times, floor of one, per-sector channel mapping
   assign mid_w = {1'b0, tim_ff.lo} + {1'b0, tim_ff.h1};
   assign hi_w  = mid_w + {1'b0, tim_ff.h2};
   assign lo_c  = at_least_one(tim_ff.lo);
   assign mid_c = at_least_one(mid_w[14:0]);
   assign hi_c  = at_least_one(hi_w[14:0]);

   always_comb begin
      b_vld_in = b_vld_ff;
      b_in     = b_ff;
      if (adv) begin
         b_vld_in    = tim_vld_ff;
         b_in.sector = tim_ff.sector;
         case (tim_ff.sector)
            SECTOR_3: begin
               b_in.duty_ch0 = hi_c;  b_in.duty_ch1 = mid_c; b_in.duty_ch2 = lo_c;
            end
            SECTOR_5: begin
               b_in.duty_ch0 = lo_c;  b_in.duty_ch1 = hi_c;  b_in.duty_ch2 = mid_c;
            end
            SECTOR_1: begin
               b_in.duty_ch0 = mid_c; b_in.duty_ch1 = hi_c;  b_in.duty_ch2 = lo_c;
            end
            SECTOR_6: begin
               b_in.duty_ch0 = mid_c; b_in.duty_ch1 = lo_c;  b_in.duty_ch2 = hi_c;
            end
            SECTOR_2: begin
               b_in.duty_ch0 = hi_c;  b_in.duty_ch1 = lo_c;  b_in.duty_ch2 = mid_c;
            end
            default: begin
               b_in.duty_ch0 = lo_c;  b_in.duty_ch1 = mid_c; b_in.duty_ch2 = hi_c;
            end
         endcase
      end
   end

   // Result fifo pointers and count
   always_comb begin
      out_wr_in  = out_push ? !out_wr_ff : out_wr_ff;
      out_rd_in  = out_pop  ? !out_rd_ff : out_rd_ff;
      out_cnt_in = out_cnt_ff;
      if (out_push && !out_pop) begin
         out_cnt_in = out_cnt_ff + 2'd1;
      end else if (out_pop && !out_push) begin
         out_cnt_in = out_cnt_ff - 2'd1;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         div_vld_ff <= '0;
         mul_vld_ff <= 1'b0;
         tim_vld_ff <= 1'b0;
         b_vld_ff   <= 1'b0;
         out_wr_ff  <= 1'b0;
         out_rd_ff  <= 1'b0;
         out_cnt_ff <= 2'd0;
      end else begin
         div_vld_ff <= div_vld_in;
         mul_vld_ff <= mul_vld_in;
         tim_vld_ff <= tim_vld_in;
         b_vld_ff   <= b_vld_in;
         out_wr_ff  <= out_wr_in;
         out_rd_ff  <= out_rd_in;
         out_cnt_ff <= out_cnt_in;
      end
   end

   // Payload stages, no reset
   always_ff @(posedge clock) begin
      div_ff <= div_in;
      mul_ff <= mul_in;
      tim_ff <= tim_in;
      b_ff   <= b_in;
      if (out_push) begin
         out_mem_ff[out_wr_ff] <= b_ff;
      end
   end

   assign rsp_empty      = (out_cnt_ff == 2'd0);
   assign rsp_duty_ch0   = out_mem_ff[out_rd_ff].duty_ch0;
   assign rsp_duty_ch1   = out_mem_ff[out_rd_ff].duty_ch1;
   assign rsp_duty_ch2   = out_mem_ff[out_rd_ff].duty_ch2;
   assign rsp_sector_num = out_mem_ff[out_rd_ff].sector;

`ifndef SYNTHESIS
   a_out_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      out_cnt_ff != 2'd3)
      else $error("result fifo count out of range");

   a_last_stage_held: assert property (@(posedge clock) disable iff (reset)
      (b_vld_ff && !adv) |=> (b_vld_ff && $stable(b_ff)))
      else $error("stalled last stage lost its request");

   a_pop_loads_div: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> div_vld_ff[0])
      else $error("queue pop did not load the divider");

   a_duty_nonzero: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_duty_ch0 != 15'd0 && rsp_duty_ch1 != 15'd0 &&
                      rsp_duty_ch2 != 15'd0))
      else $error("zero compare value on result");
`endif

endmodule

`default_nettype wire

>>> rtl/space_vector_pwm_timing_core.sv
// Space-vector PWM sector timing core: top level with the period register.
// Request path to the rsp_ ports: queue, 15-step divider, multiply, low-time and mapping
// stages, result fifo. Throughput: one request per cycle while the result fifo is not full.
// Reset: synchronous, active high; empties queue and pipeline, period returns to 2400.
// Depends on svpt_pkg, svpt_front, svpt_queue and svpt_back.
`default_nettype none

module space_vector_pwm_timing_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_push,
   output logic                req_full,
   input  logic signed [15:0]  req_ref_a,
   input  logic signed [15:0]  req_ref_b,
   input  logic signed [15:0]  req_ref_c,
   output logic                rsp_empty,
   input  logic                rsp_pop,
   output logic [14:0]         rsp_duty_ch0,
   output logic [14:0]         rsp_duty_ch1,
   output logic [14:0]         rsp_duty_ch2,
   output logic [2:0]          rsp_sector_num,
   input  logic                csr_wr_en,
   input  logic [14:0]         csr_wr_data
);
   import svpt_pkg::*;

   logic [14:0] pwm_period_ff, pwm_period_in;
   logic        q_full, q_push, q_pop, q_empty;
   cls_type     q_wr_item, q_rd_item;

   // PWM period register
   assign pwm_period_in = csr_wr_en ? csr_wr_data : pwm_period_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pwm_period_ff <= PERIOD_RESET;
      end else begin
         pwm_period_ff <= pwm_period_in;
      end
   end

   svpt_front u_front (
      .req_push (req_push),
      .req_full (req_full),
      .ref_a    (req_ref_a),
      .ref_b    (req_ref_b),
      .ref_c    (req_ref_c),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_item   (q_wr_item)
   );

   svpt_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .item_in  (q_wr_item),
      .full     (q_full),
      .pop      (q_pop),
      .item_out (q_rd_item),
      .empty    (q_empty)
   );

   svpt_back u_back (
      .clock          (clock),
      .reset          (reset),
      .period         (pwm_period_ff),
      .q_empty        (q_empty),
      .q_item         (q_rd_item),
      .q_pop          (q_pop),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_duty_ch0   (rsp_duty_ch0),
      .rsp_duty_ch1   (rsp_duty_ch1),
      .rsp_duty_ch2   (rsp_duty_ch2),
      .rsp_sector_num (rsp_sector_num)
   );

endmodule

`default_nettype wire
